// ----- design/msl_pkg.sv -----
// Shared types, constants and helpers for the multi-bank sorted list core.
package msl_pkg;

  localparam int STORES   = 4;
  localparam int CAPACITY = 16;

  localparam int CODE_W   = 27;
  localparam int CMD_W    = 2;
  localparam int BANK_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CFG_W    = 3;

  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int REM_W    = $clog2(STORES * CAPACITY + 1);
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOBANK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  localparam logic REG_BANKS_IN_USE = 1'b0;

  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_INS  = 2'd1;
  localparam cell_op_t OP_DEL  = 2'd2;
  localparam cell_op_t OP_ROT  = 2'd3;

  typedef struct packed {
    logic              match;
    logic [OCC_W-1:0]  occ;
    logic [CODE_W-1:0] head;
  } bank_stat_t;

  function automatic logic [COUNT_W-1:0] count_sat(input logic [REM_W-1:0] n);
    logic [COUNT_W-1:0] r;
    if (int'(n) > COUNT_MAX) begin
      r = COUNT_W'(COUNT_MAX);
    end else begin
      r = COUNT_W'(n);
    end
    return r;
  endfunction

endpackage

// ----- design/msl_cell.sv -----
// One compare-and-shift cell holding a single code of a bank.
module msl_cell (
  input  logic                      clk,
  input  msl_pkg::cell_op_t         op,
  input  logic [msl_pkg::CODE_W-1:0] code,
  input  logic                      valid,
  input  logic                      tail,
  input  logic [msl_pkg::CODE_W-1:0] left_entry,
  input  logic                      left_lt,
  input  logic [msl_pkg::CODE_W-1:0] right_entry,
  input  logic [msl_pkg::CODE_W-1:0] wrap_entry,
  output logic [msl_pkg::CODE_W-1:0] entry,
  output logic                      lt,
  output logic                      eq
);

  logic [msl_pkg::CODE_W-1:0] entry_r;
  logic [msl_pkg::CODE_W-1:0] entry_nxt;

  assign entry = entry_r;
  assign lt    = valid && (entry_r < code);
  assign eq    = valid && (entry_r == code);

  always_comb begin
    unique case (op)
      msl_pkg::OP_INS:  entry_nxt = lt ? entry_r : (left_lt ? code : left_entry);
      msl_pkg::OP_DEL:  entry_nxt = lt ? entry_r : right_entry;
      msl_pkg::OP_ROT:  entry_nxt = tail ? wrap_entry : right_entry;
      default:          entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- design/msl_bank.sv -----
// One bank: a row of cells plus its occupancy counter.
module msl_bank (
  input  logic                       clk,
  input  logic                       rst_n,
  input  msl_pkg::cell_op_t          op,
  input  logic [msl_pkg::CODE_W-1:0] code,
  output msl_pkg::bank_stat_t        stat
);

  localparam int N = msl_pkg::CAPACITY;

  logic [msl_pkg::OCC_W-1:0]  occ_r;
  logic [msl_pkg::OCC_W-1:0]  occ_nxt;
  logic [msl_pkg::CODE_W-1:0] entry [N];
  logic [N-1:0]               lt;
  logic [N-1:0]               eq;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [msl_pkg::CODE_W-1:0] left_e;
    logic [msl_pkg::CODE_W-1:0] right_e;
    logic                       left_l;
    logic                       valid;
    logic                       tail;

    if (i == 0) begin : g_first
      assign left_e = code;
      assign left_l = 1'b0;
    end else begin : g_mid
      assign left_e = entry[i-1];
      assign left_l = lt[i-1];
    end

    if (i == N - 1) begin : g_lastc
      assign right_e = entry[i];
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    assign valid = occ_r > msl_pkg::OCC_W'(i);
    assign tail  = occ_r == msl_pkg::OCC_W'(i + 1);

    msl_cell u_cell (
      .clk         (clk),
      .op          (op),
      .code        (code),
      .valid       (valid),
      .tail        (tail),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .wrap_entry  (entry[0]),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .eq          (eq[i])
    );
  end

  always_comb begin
    occ_nxt = occ_r;
    if (op == msl_pkg::OP_INS) begin
      occ_nxt = occ_r + 1'b1;
    end else if (op == msl_pkg::OP_DEL) begin
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign stat.match = |eq;
  assign stat.occ   = occ_r;
  assign stat.head  = entry[0];

endmodule

// ----- design/multi_bank_sorted_list_core.sv -----
// Top level: command decode, remove/list sequencer and the bank rows.
//
//  channel  | handshake             | beat contents
//  ---------+-----------------------+----------------------------------
//  input    | start & !busy         | in_cmd, in_bank, in_code
//  result   | out_valid (no stall)  | out_status, out_code_out, out_count, out_last
//  config   | psel&penable&pwrite   | paddr, pwdata (prdata on read)
//
// Insert: sorted into the selected bank's cell row; result the next cycle, busy stays low.
// Remove: busy until no bank in use still holds the code
//   (the cells drop one match per bank per cycle).
// List: one beat per code, without gaps (the bank row rotates back into place), min 1 beat.
// Synchronous active-low reset clears occupancy and control; codes are not reset.
// Results are one-cycle strobes; the receiver cannot stall.
module multi_bank_sorted_list_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [msl_pkg::CMD_W-1:0]    in_cmd,
  input  logic [msl_pkg::BANK_W-1:0]   in_bank,
  input  logic [msl_pkg::CODE_W-1:0]   in_code,
  output logic                         out_valid,
  output logic [msl_pkg::STATUS_W-1:0] out_status,
  output logic [msl_pkg::CODE_W-1:0]   out_code_out,
  output logic [msl_pkg::COUNT_W-1:0]  out_count,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int S = msl_pkg::STORES;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REM  = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [msl_pkg::CFG_W-1:0]    banks_r;
  logic [msl_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic [msl_pkg::REM_W-1:0]    acc_r, acc_nxt;
  logic [msl_pkg::OCC_W-1:0]    idx_r, idx_nxt;
  logic [S-1:0]                 lsel_r, lsel_nxt;

  logic                         ov_r, ov_nxt;
  logic [msl_pkg::STATUS_W-1:0] ost_r, ost_nxt;
  logic [msl_pkg::CODE_W-1:0]   ocode_r, ocode_nxt;
  logic [msl_pkg::COUNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic                         olast_r, olast_nxt;

  msl_pkg::cell_op_t            op [S];
  msl_pkg::bank_stat_t          stat [S];
  logic [S-1:0]                 in_use;
  logic [S-1:0]                 isel;
  logic [msl_pkg::CODE_W-1:0]   cmp_code;
  logic                         accept;
  logic                         cfg_wr;

  assign accept   = start && !busy;
  assign busy     = state_r != S_IDLE;
  assign cmp_code = (state_r == S_REM) ? code_r : in_code;
  assign cfg_wr   = psel && penable && pwrite && pready;

  for (genvar s = 0; s < S; s++) begin : g_bank
    assign in_use[s] = s < int'(banks_r);
    assign isel[s]   = int'(in_bank) == s;

    msl_bank u_bank (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op[s]),
      .code  (cmp_code),
      .stat  (stat[s])
    );
  end

  always_comb begin
    logic                       ok;
    logic [msl_pkg::OCC_W-1:0]  iocc;
    logic [msl_pkg::OCC_W-1:0]  locc;
    logic [msl_pkg::CODE_W-1:0] lhead;
    logic                       any;
    logic [msl_pkg::REM_W-1:0]  hits;

    ok    = |(isel & in_use);
    iocc  = '0;
    locc  = '0;
    lhead = '0;
    any   = 1'b0;
    hits  = '0;
    for (int s = 0; s < S; s++) begin
      if (isel[s]) iocc = iocc | stat[s].occ;
      if (lsel_r[s]) begin
        locc  = locc | stat[s].occ;
        lhead = lhead | stat[s].head;
      end
      if (in_use[s] && stat[s].match) begin
        any  = 1'b1;
        hits = hits + 1'b1;
      end
    end

    for (int s = 0; s < S; s++) op[s] = msl_pkg::OP_HOLD;
    state_nxt = state_r;
    code_nxt  = code_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    lsel_nxt  = lsel_r;
    ov_nxt    = 1'b0;
    ost_nxt   = msl_pkg::ST_OK;
    ocode_nxt = '0;
    ocnt_nxt  = '0;
    olast_nxt = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            msl_pkg::CMD_INSERT: begin
              ov_nxt = 1'b1;
              if (!ok) begin
                ost_nxt = msl_pkg::ST_NOBANK;
              end else if (int'(iocc) >= msl_pkg::CAPACITY) begin
                ost_nxt  = msl_pkg::ST_FULL;
                ocnt_nxt = msl_pkg::count_sat(msl_pkg::REM_W'(iocc));
              end else begin
                for (int s = 0; s < S; s++) begin
                  if (isel[s]) op[s] = msl_pkg::OP_INS;
                end
                ocnt_nxt = msl_pkg::count_sat(msl_pkg::REM_W'(iocc + 1'b1));
              end
            end
            msl_pkg::CMD_REMOVE: begin
              code_nxt  = in_code;
              acc_nxt   = '0;
              state_nxt = S_REM;
            end
            msl_pkg::CMD_LIST: begin
              if (!ok) begin
                ov_nxt  = 1'b1;
                ost_nxt = msl_pkg::ST_NOBANK;
              end else if (iocc == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = msl_pkg::ST_EMPTY;
              end else begin
                lsel_nxt  = isel;
                idx_nxt   = '0;
                state_nxt = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_REM: begin
        if (any) begin
          for (int s = 0; s < S; s++) begin
            if (in_use[s] && stat[s].match) op[s] = msl_pkg::OP_DEL;
          end
          acc_nxt = acc_r + hits;
        end else begin
          ov_nxt    = 1'b1;
          ocnt_nxt  = msl_pkg::count_sat(acc_r);
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        for (int s = 0; s < S; s++) begin
          if (lsel_r[s]) op[s] = msl_pkg::OP_ROT;
        end
        ov_nxt    = 1'b1;
        ocode_nxt = lhead;
        ocnt_nxt  = msl_pkg::count_sat(msl_pkg::REM_W'(locc));
        olast_nxt = (idx_r + 1'b1) == locc;
        idx_nxt   = idx_r + 1'b1;
        if (olast_nxt) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      banks_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr && paddr[2] == msl_pkg::REG_BANKS_IN_USE) begin
        banks_r <= pwdata[msl_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    acc_r   <= acc_nxt;
    idx_r   <= idx_nxt;
    lsel_r  <= lsel_nxt;
    ost_r   <= ost_nxt;
    ocode_r <= ocode_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_code_out = ocode_r;
  assign out_count    = ocnt_r;
  assign out_last     = olast_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == msl_pkg::REG_BANKS_IN_USE) ? 32'(banks_r) : '0;

endmodule

// ----- design/msl_checker.sv -----
// Port-level checks for the multi-bank sorted list core, bound to the top level.
module msl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [msl_pkg::CMD_W-1:0]    in_cmd,
  input logic                         out_valid,
  input logic [msl_pkg::STATUS_W-1:0] out_status,
  input logic [msl_pkg::CODE_W-1:0]   out_code_out,
  input logic [msl_pkg::COUNT_W-1:0]  out_count,
  input logic                         out_last
);

  // a list streams without gaps until its last beat
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("list stream broke before last beat");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != msl_pkg::ST_OK |-> out_last)
    else $error("error status on a non-final beat");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == msl_pkg::ST_EMPTY || out_status == msl_pkg::ST_NOBANK)
    |-> out_count == '0 && out_code_out == '0)
    else $error("empty or disabled bank reported data");

  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd == msl_pkg::CMD_INSERT |=> out_valid && out_last && !busy)
    else $error("insert did not answer in one cycle");

endmodule

bind multi_bank_sorted_list_core msl_checker u_msl_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_cmd       (in_cmd),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_code_out (out_code_out),
  .out_count    (out_count),
  .out_last     (out_last)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for multi_bank_sorted_list_core: random commands and beat scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam logic [2:0]       ADDR_BANKS  = 3'(4 * REG_BANKS_IN_USE);
  localparam logic [2:0]       ADDR_SPARE  = 3'd4;
  localparam int               QUIET_CYCLES = 20;
  localparam int               TAIL_CYCLES  = 40;
  localparam int               STALL_LIMIT  = 2000;
  localparam int               PHASES       = 9;
  localparam int               PHASE_ITEMS  = 50;

  typedef enum logic [1:0] {PK_ITEM, PK_CFG, PK_DRAIN} plan_kind_t;

  typedef struct packed {
    plan_kind_t        kind;
    logic [CMD_W-1:0]  cmd;
    logic [BANK_W-1:0] bank;
    logic [CODE_W-1:0] code;
    logic [2:0]        addr;
    logic [31:0]       data;
    logic [7:0]        gap;
  } plan_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CODE_W-1:0]   code;
    logic [COUNT_W-1:0]  count;
    logic                last;
  } sl_beat_t;

  typedef enum logic [2:0] {
    DS_FETCH, DS_ITEM, DS_DRAIN, DS_QUIET, DS_SETUP, DS_ACCESS, DS_DONE
  } drv_state_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd = '0;
  logic [BANK_W-1:0]   in_bank = '0;
  logic [CODE_W-1:0]   in_code = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CODE_W-1:0]   out_code_out;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  multi_bank_sorted_list_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_bank      (in_bank),
    .in_code      (in_code),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_code_out (out_code_out),
    .out_count    (out_count),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mirror of the bank contents
  logic [CODE_W-1:0] bank_codes [STORES][CAPACITY];
  int                bank_fill  [STORES];
  logic [CFG_W-1:0]  banks_on;

  sl_beat_t   pending_beats [$];
  plan_t      plan_q [$];
  plan_t      cur;
  drv_state_t drv_st;
  int         gap_left;
  int         quiet;
  int         mismatches = 0;
  int         idle_cycles = 0;
  logic       stim_done = 1'b0;

  function automatic bit bank_live(input int b);
    return (b < int'(banks_on)) && (b < STORES);
  endfunction

  function automatic void push_beat(input logic [STATUS_W-1:0] st,
                                    input logic [CODE_W-1:0] cd,
                                    input int cnt, input logic lst);
    sl_beat_t bt;
    bt.status = st;
    bt.code   = cd;
    bt.count  = (cnt > 127) ? 7'd127 : COUNT_W'(cnt);
    bt.last   = lst;
    pending_beats.push_back(bt);
  endfunction

  function automatic void apply_register_write(input logic [2:0] addr, input logic [31:0] data);
    if ((addr >> 2) == 3'(REG_BANKS_IN_USE)) banks_on = data[CFG_W-1:0];
  endfunction

  function automatic void sorted_list_update(input plan_t it);
    int b, n, pos, i, s, r, w, removed;
    b = int'(it.bank);
    case (it.cmd)
      CMD_INSERT: begin
        if (!bank_live(b)) begin
          push_beat(ST_NOBANK, '0, 0, 1'b1);
        end else begin
          n = bank_fill[b];
          if (n >= CAPACITY) begin
            push_beat(ST_FULL, '0, n, 1'b1);
          end else begin
            pos = 0;
            while (pos < n && bank_codes[b][pos] < it.code) pos++;
            for (i = n; i > pos; i--) bank_codes[b][i] = bank_codes[b][i-1];
            bank_codes[b][pos] = it.code;
            bank_fill[b] = n + 1;
            push_beat(ST_OK, '0, n + 1, 1'b1);
          end
        end
      end
      CMD_REMOVE: begin
        removed = 0;
        for (s = 0; s < STORES; s++) begin
          if (bank_live(s)) begin
            w = 0;
            for (r = 0; r < bank_fill[s]; r++) begin
              if (bank_codes[s][r] == it.code) begin
                removed++;
              end else begin
                bank_codes[s][w] = bank_codes[s][r];
                w++;
              end
            end
            bank_fill[s] = w;
          end
        end
        push_beat(ST_OK, '0, removed, 1'b1);
      end
      CMD_LIST: begin
        if (!bank_live(b)) begin
          push_beat(ST_NOBANK, '0, 0, 1'b1);
        end else if (bank_fill[b] == 0) begin
          push_beat(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          n = bank_fill[b];
          for (i = 0; i < n; i++) push_beat(ST_OK, bank_codes[b][i], n, (i + 1 == n));
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    logic start_nxt;
    if (!rst_n) begin
      start    <= 1'b0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      drv_st   = DS_FETCH;
      gap_left = 0;
      quiet    = 0;
      banks_on = '0;
      for (int s = 0; s < STORES; s++) bank_fill[s] = 0;
    end else begin
      start_nxt = start;
      if (drv_st == DS_ITEM && start && !busy) begin
        sorted_list_update(cur);
        start_nxt = 1'b0;
        gap_left  = int'(cur.gap);
        drv_st    = DS_FETCH;
      end
      case (drv_st)
        DS_FETCH: begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (plan_q.size() == 0) begin
            drv_st = DS_DONE;
            stim_done <= 1'b1;
          end else begin
            cur = plan_q.pop_front();
            case (cur.kind)
              PK_ITEM: begin
                in_cmd    <= cur.cmd;
                in_bank   <= cur.bank;
                in_code   <= cur.code;
                start_nxt = 1'b1;
                drv_st    = DS_ITEM;
              end
              PK_CFG: begin
                quiet  = 0;
                drv_st = DS_QUIET;
              end
              default: drv_st = DS_DRAIN;
            endcase
          end
        end
        DS_DRAIN: if (pending_beats.size() == 0) drv_st = DS_FETCH;
        DS_QUIET: begin
          if (pending_beats.size() == 0 && !busy) quiet++;
          else quiet = 0;
          if (quiet >= QUIET_CYCLES) begin
            psel   <= 1'b1;
            pwrite <= 1'b1;
            paddr  <= cur.addr;
            pwdata <= cur.data;
            drv_st = DS_SETUP;
          end
        end
        DS_SETUP: begin
          penable <= 1'b1;
          drv_st = DS_ACCESS;
        end
        DS_ACCESS: if (pready) begin
          apply_register_write(cur.addr, cur.data);
          psel    <= 1'b0;
          penable <= 1'b0;
          pwrite  <= 1'b0;
          drv_st = DS_FETCH;
        end
        default: ;
      endcase
      start <= start_nxt;
    end
  end

  function automatic void note_mismatch(input string why, input sl_beat_t want,
                                        input sl_beat_t got);
    if (mismatches < 10)
      $display("%s: expected status %0d code %0d count %0d last %0d, %s %0d %s %0d %s %0d %s %0d",
               why, want.status, want.code, want.count, want.last,
               "got status", got.status, "code", got.code,
               "count", got.count, "last", got.last);
    mismatches++;
  endfunction

  // monitor
  always @(posedge clk) begin
    sl_beat_t got, want;
    if (rst_n && out_valid === 1'b1) begin
      got = {out_status, out_code_out, out_count, out_last};
      if (pending_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, got);
      end else begin
        want = pending_beats.pop_front();
        if (got.status !== want.status || got.code !== want.code ||
            got.count !== want.count || got.last !== want.last)
          note_mismatch("beat mismatch", want, got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid === 1'b1 || (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no progress for %0d cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic void add_item(input logic [CMD_W-1:0] cmd, input logic [BANK_W-1:0] bank,
                                   input logic [CODE_W-1:0] code, input int gap);
    plan_t p;
    p = '0;
    p.kind = PK_ITEM;
    p.cmd  = cmd;
    p.bank = bank;
    p.code = code;
    p.gap  = 8'(gap);
    plan_q.push_back(p);
  endfunction

  function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] data);
    plan_t p;
    p = '0;
    p.kind = PK_CFG;
    p.addr = addr;
    p.data = data;
    plan_q.push_back(p);
  endfunction

  function automatic void add_drain();
    plan_t p;
    p = '0;
    p.kind = PK_DRAIN;
    plan_q.push_back(p);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(input logic [CODE_W-1:0] code_pool [6]);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return code_pool[$urandom_range(0, 5)];
    if (r < 8) return 27'($urandom());
    if (r == 8) return $urandom_range(0, 1) ? 27'h7FF_FFFF : 27'd0;
    return 27'd99999999;
  endfunction

  // stimulus and end of run
  initial begin
    logic [CODE_W-1:0] code_pool [6];
    logic [CFG_W-1:0]  phase_cfg [PHASES];
    int ph, k, r, ins_pct, rem_pct;
    bit bursty;

    phase_cfg = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd5, 3'd2, 3'd6, 3'd4};

    add_cfg(ADDR_SPARE, 32'h0000_0007);
    add_item(CMD_INSERT, 2'd0, 27'd5, 0);
    add_item(CMD_LIST, 2'd0, 27'd0, 1);
    add_item(CMD_REMOVE, 2'd2, 27'd5, 0);
    add_cfg(ADDR_BANKS, 32'hFFFF_FFFC);
    add_item(CMD_INSERT, 2'd0, 27'd99999999, 0);
    add_item(CMD_INSERT, 2'd0, 27'd0, 0);
    add_item(CMD_INSERT, 2'd0, 27'h7FF_FFFF, 2);
    add_item(CMD_INSERT, 2'd0, 27'd0, 0);
    add_item(CMD_INSERT, 2'd3, 27'd0, 0);
    add_item(CMD_INSERT, 2'd1, 27'd12345678, 0);
    add_item(CMD_LIST, 2'd0, 27'h7FF_FFFF, 0);
    add_item(CMD_UNUSED, 2'd2, 27'h555_5555, 3);
    add_item(CMD_REMOVE, 2'd1, 27'd0, 0);
    add_item(CMD_LIST, 2'd0, 27'd0, 0);
    add_item(CMD_LIST, 2'd2, 27'd0, 1);
    add_item(CMD_LIST, 2'd3, 27'd0, 0);
    add_cfg(ADDR_BANKS, 32'h0000_0007);
    add_item(CMD_INSERT, 2'd2, 27'd42, 0);
    add_item(CMD_LIST, 2'd2, 27'd0, 0);
    add_item(CMD_LIST, 2'd1, 27'd0, 0);
    add_cfg(ADDR_BANKS, 32'h0000_0001);
    add_item(CMD_INSERT, 2'd1, 27'd7, 0);
    add_item(CMD_LIST, 2'd3, 27'd0, 0);
    add_item(CMD_REMOVE, 2'd0, 27'd12345678, 0);
    add_item(CMD_LIST, 2'd0, 27'd0, 0);

    for (ph = 0; ph < PHASES; ph++) begin
      for (k = 0; k < 6; k++)
        code_pool[k] = $urandom_range(0, 1) ? 27'($urandom()) : 27'($urandom_range(0, 15));
      add_cfg(ADDR_BANKS, {29'($urandom()), phase_cfg[ph]});
      if ($urandom_range(0, 99) < 30) add_cfg(ADDR_SPARE, $urandom());
      bursty  = (ph % 3 == 2);
      ins_pct = (ph % 2 == 1) ? 65 : 45;
      rem_pct = (ph % 4 == 1) ? 4 : 18;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct)
          add_item(CMD_INSERT, $urandom_range(0, 1) ? 2'd0 : 2'($urandom_range(0, 3)),
                   pick_code(code_pool), bursty ? 0 : pick_gap());
        else if (r < ins_pct + rem_pct)
          add_item(CMD_REMOVE, 2'($urandom_range(0, 3)), pick_code(code_pool),
                   bursty ? 0 : pick_gap());
        else if (r < 96)
          add_item(CMD_LIST, 2'($urandom_range(0, 3)), 27'($urandom()),
                   bursty ? 0 : pick_gap());
        else
          add_item(CMD_UNUSED, 2'($urandom_range(0, 3)), 27'($urandom()),
                   bursty ? 0 : pick_gap());
        if ($urandom_range(0, 99) < 3) add_drain();
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (stim_done);
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
